### rtl/lc2_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc2_pkg
// Shared types, constants and helpers of the lc2 spectrum decoder.
// ----------------------------------------------------------------------------
package lc2_pkg;

    localparam int SAMPLE_W = 32;
    localparam int COUNT_W  = 25;
    localparam int ACC_W    = 34;
    localparam int NEED_W   = ACC_W + 1;

    localparam logic [COUNT_W-1:0] TOTAL_RESET = COUNT_W'(8192);
    localparam logic [5:0]         EXT_BASE    = 6'd59;
    localparam logic [7:0]         CLASS_COUNT = 8'h80;
    localparam logic [7:0]         CLASS_PAIR  = 8'h40;
    localparam logic [7:0]         COUNT_MASK  = 8'h3f;
    localparam logic [ACC_W-1:0]   RUN_OFFSET  = ACC_W'(3);

    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = 1;
    localparam int CMD_CNT_W = 2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [COUNT_W-1:0]         t_count;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       start_flag;
    } t_in_item;

    typedef struct packed {
        t_sample sample_value;
        t_count  repeat_count;
        logic    group_end;
        logic    spectrum_done;
        logic    decode_error;
    } t_out_item;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_DECODE = 4'b0010,
        PH_EXT    = 4'b0100,
        PH_ERROR  = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        K_GRP3  = 3'd0,
        K_GRP2  = 3'd1,
        K_DELTA = 3'd2,
        K_RUN   = 3'd3,
        K_ERR   = 3'd4
    } t_kind;

    // one classified byte waiting for the result sequencer
    typedef struct packed {
        t_kind   kind;
        t_sample base;
        t_sample delta;
        t_count  run_cnt;
        logic    done;
    } t_cmd;

    function automatic t_sample zigzag(input logic [ACC_W-1:0] k);
        logic [ACC_W-2:0] h;
        h = k[ACC_W-1:1];
        return k[0] ? ~t_sample'(SAMPLE_W'(h)) : t_sample'(SAMPLE_W'(h));
    endfunction

endpackage

### rtl/lc2_spectrum_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc2_spectrum_decoder
// Byte-serial decoder for one lc2-compressed spectrum.
// ----------------------------------------------------------------------------
// A code byte is accepted in any cycle in which the two-entry command queue
// has room; the classifier updates the running value and the sample count
// in that same cycle. Each byte then yields result items: group bytes three
// or two, a delta header one, a run header two, an overrun one, and
// extension bytes that complete no header none. The result port, one item
// per cycle unless the output stalls, sets the sustained rate; results pass
// through the command queue and then the output register. Configuration
// writes are always taken and must only be issued while the block is idle.
module lc2_spectrum_decoder
    import lc2_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  t_count    i_cfg_data
);

    logic in_accept;
    logic fifo_push;
    logic fifo_pop;
    logic fifo_full;
    logic fifo_empty;
    t_cmd push_cmd;
    t_cmd head_cmd;

    assign o_in_ready  = !fifo_full;
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && o_in_ready;

    lc2_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_accept   (in_accept),
        .i_item     (i_in_data),
        .o_push     (fifo_push),
        .o_cmd      (push_cmd)
    );

    lc2_cmd_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (fifo_push),
        .i_data (push_cmd),
        .o_full (fifo_full),
        .i_pop  (fifo_pop),
        .o_data (head_cmd),
        .o_empty(fifo_empty)
    );

    lc2_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (fifo_empty),
        .i_cmd      (head_cmd),
        .o_pop      (fifo_pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

`ifndef SYNTH
    a_err_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.decode_error |->
            o_out_data.sample_value == '0 && o_out_data.repeat_count == '0
            && o_out_data.group_end && !o_out_data.spectrum_done)
        else $error("error item malformed");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.decode_error |-> o_out_data.repeat_count != '0)
        else $error("zero repeat count on a sample item");

    a_done_ends_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.spectrum_done |-> o_out_data.group_end)
        else $error("spectrum done off the group end");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_pop |-> !fifo_empty)
        else $error("command queue underflow");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_push |-> !fifo_full)
        else $error("command queue overflow");
`endif

endmodule

### rtl/lc2_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc2_front
// Accepts code bytes, tracks decoder state and classifies each byte into a
// command for the result sequencer.
// ----------------------------------------------------------------------------
module lc2_front
    import lc2_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    input  t_count       i_cfg_data,
    input  logic         i_accept,
    input  t_in_item     i_item,
    output logic         o_push,
    output t_cmd         o_cmd
);

    t_count             r_total;
    t_sample            r_last,     n_last;
    t_count             r_left,     n_left;
    logic [2:0]         r_ext_left, n_ext_left;
    logic [1:0]         r_ext_idx,  n_ext_idx;
    logic [ACC_W-1:0]   r_acc,      n_acc;
    logic               r_run,      n_run;
    t_phase             r_phase,    n_phase;

    t_sample            e_last;
    t_count             e_left;
    t_phase             e_phase;
    logic [7:0]         code;
    logic [ACC_W-1:0]   ext_add;
    logic [ACC_W-1:0]   acc_sum;
    logic [ACC_W-1:0]   cnt_n;
    logic               do_count;
    logic               cnt_run;
    logic               do_group;
    logic               emit;
    t_kind              kind;
    logic [NEED_W-1:0]  need;
    t_sample            addend;
    t_sample            delta;
    t_count             run_cnt;
    t_count             left_after;

    assign code    = i_item.code_byte;
    assign e_last  = i_item.start_flag ? '0 : r_last;
    assign e_left  = i_item.start_flag ? r_total : r_left;
    assign e_phase = i_item.start_flag ? PH_DECODE : r_phase;

    assign ext_add = ACC_W'({1'b0, code} + 9'd1) << {r_ext_idx, 3'b000};
    assign acc_sum = r_acc + ext_add;

    always_comb begin
        n_last     = r_last;
        n_left     = r_left;
        n_ext_left = r_ext_left;
        n_ext_idx  = r_ext_idx;
        n_acc      = r_acc;
        n_run      = r_run;
        n_phase    = r_phase;
        do_count   = 1'b0;
        do_group   = 1'b0;
        cnt_n      = ACC_W'(code & COUNT_MASK);
        cnt_run    = code[6];
        o_push     = 1'b0;

        if (i_accept) begin
            if (i_item.start_flag) begin
                n_last     = '0;
                n_left     = r_total;
                n_ext_left = '0;
                n_ext_idx  = '0;
                n_acc      = '0;
                n_run      = 1'b0;
                n_phase    = PH_DECODE;
            end
            case (e_phase)
                PH_EXT: begin
                    n_acc      = acc_sum;
                    n_ext_idx  = r_ext_idx + 2'd1;
                    n_ext_left = r_ext_left - 3'd1;
                    cnt_n      = acc_sum;
                    cnt_run    = r_run;
                    if (r_ext_left == 3'd1) begin
                        n_phase  = PH_DECODE;
                        do_count = 1'b1;
                    end
                end
                PH_DECODE: begin
                    if ((code & CLASS_COUNT) != '0) begin
                        n_run = code[6];
                        if (code[5:0] > EXT_BASE) begin
                            n_ext_left = 3'(code[5:0] - EXT_BASE);
                            n_ext_idx  = '0;
                            n_acc      = ACC_W'(EXT_BASE);
                            n_phase    = PH_EXT;
                        end else begin
                            do_count = 1'b1;
                        end
                    end else begin
                        do_group = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        // classify what the byte emits and how many samples it needs
        emit    = do_count | do_group;
        kind    = K_DELTA;
        need    = NEED_W'(1);
        addend  = '0;
        delta   = '0;
        run_cnt = COUNT_W'(1);
        if (do_group) begin
            delta = t_sample'(SAMPLE_W'(code[5:0]));
            if ((code & CLASS_PAIR) != '0) begin
                kind   = K_GRP2;
                need   = NEED_W'(2);
                addend = zigzag(ACC_W'(code[5:3]));
            end else begin
                kind   = K_GRP3;
                need   = NEED_W'(3);
                addend = zigzag(ACC_W'(code[5:4]));
            end
        end else if (cnt_run) begin
            kind    = K_RUN;
            need    = NEED_W'(cnt_n >> 1) + NEED_W'(4);
            delta   = t_sample'(SAMPLE_W'(cnt_n[0]));
            run_cnt = COUNT_W'((cnt_n >> 1) + RUN_OFFSET);
        end else begin
            addend = zigzag(cnt_n);
            delta  = addend;
        end

        left_after = e_left - COUNT_W'(need);

        o_cmd.kind    = kind;
        o_cmd.base    = e_last;
        o_cmd.delta   = delta;
        o_cmd.run_cnt = run_cnt;
        o_cmd.done    = (left_after == '0);

        if (emit) begin
            o_push = 1'b1;
            if (need > NEED_W'(e_left)) begin
                o_cmd.kind = K_ERR;
                o_cmd.done = 1'b0;
                n_phase    = PH_ERROR;
            end else begin
                n_left = left_after;
                n_last = e_last + addend;
                if (left_after == '0) begin
                    n_phase = PH_IDLE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= TOTAL_RESET;
            r_last     <= '0;
            r_left     <= '0;
            r_ext_left <= '0;
            r_ext_idx  <= '0;
            r_acc      <= '0;
            r_run      <= 1'b0;
            r_phase    <= PH_IDLE;
        end else begin
            if (i_cfg_valid) begin
                r_total <= i_cfg_data;
            end
            r_last     <= n_last;
            r_left     <= n_left;
            r_ext_left <= n_ext_left;
            r_ext_idx  <= n_ext_idx;
            r_acc      <= n_acc;
            r_run      <= n_run;
            r_phase    <= n_phase;
        end
    end

endmodule

### rtl/lc2_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc2_cmd_fifo
// Short command queue between the byte classifier and the result sequencer.
// ----------------------------------------------------------------------------
module lc2_cmd_fifo
    import lc2_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty
);

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr;
    logic [CMD_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CMD_CNT_W'(CMD_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/lc2_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc2_back
// Result sequencer: expands one command into its result items, one per
// cycle unless the output stalls, into the output register.
// ----------------------------------------------------------------------------
module lc2_back
    import lc2_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic [1:0] r_idx;
    logic [1:0] last_idx;
    logic       r_valid;
    t_out_item  r_data;
    t_out_item  item;
    t_sample    addend;
    logic       take;
    logic       is_last;

    always_comb begin
        case (i_cmd.kind)
            K_GRP3:  last_idx = 2'd2;
            K_GRP2:  last_idx = 2'd1;
            K_RUN:   last_idx = 2'd1;
            default: last_idx = 2'd0;
        endcase
    end

    assign is_last = (r_idx == last_idx);
    assign take    = !i_empty && (!r_valid || i_out_ready);
    assign o_pop   = take && is_last;

    always_comb begin
        addend = '0;
        case (i_cmd.kind)
            K_GRP3: begin
                case (r_idx)
                    2'd0:    addend = zigzag(ACC_W'(i_cmd.delta[1:0]));
                    2'd1:    addend = zigzag(ACC_W'(i_cmd.delta[3:2]));
                    default: addend = zigzag(ACC_W'(i_cmd.delta[5:4]));
                endcase
            end
            K_GRP2: begin
                if (r_idx == 2'd0) begin
                    addend = zigzag(ACC_W'(i_cmd.delta[2:0]));
                end else begin
                    addend = zigzag(ACC_W'(i_cmd.delta[5:3]));
                end
            end
            K_DELTA: addend = i_cmd.delta;
            K_RUN:   addend = (r_idx == 2'd0) ? i_cmd.delta : '0;
            default: addend = '0;
        endcase

        item.sample_value  = i_cmd.base + addend;
        item.repeat_count  = COUNT_W'(1);
        item.group_end     = is_last;
        item.spectrum_done = is_last && i_cmd.done;
        item.decode_error  = 1'b0;
        if (i_cmd.kind == K_RUN && r_idx != 2'd0) begin
            item.repeat_count = i_cmd.run_cnt;
        end
        if (i_cmd.kind == K_ERR) begin
            item.sample_value  = '0;
            item.repeat_count  = '0;
            item.group_end     = 1'b1;
            item.spectrum_done = 1'b0;
            item.decode_error  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_data <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_valid <= 1'b1;
                r_idx   <= is_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule
